/* sv/radial_source_cost_cell_top_defines.svh */
// Assertion macros for the radial source cost cell checker.
// Depends on nothing; included by the checker file only.
`ifndef RADIAL_SOURCE_COST_CELL_TOP_DEFINES_SVH
`define RADIAL_SOURCE_COST_CELL_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define RSCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define RSCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/rscc_pkg.sv */
// Shared widths, constants and types of the radial source cost cell.
// Depends on nothing; used by every module of the block but the checker.
package rscc_pkg;

    localparam int COORD_W    = 32;
    localparam int STR_W      = 24;
    localparam int RAD_W      = 20;
    localparam int CS_W       = 16;
    localparam int IDX_IN_W   = 16;
    localparam int COST_W     = 8;
    localparam int R_W        = RAD_W + 1;
    localparam int D2_W       = 2 * R_W;
    localparam int DEN_W      = STR_W + R_W;
    localparam int NUM1_W     = STR_W + R_W;
    localparam int NUM_W      = NUM1_W + 8;
    localparam int QUOT_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int INDEX_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_POS_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_POS_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_STRENGTH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REACH_RADIUS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_STRENGTH_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ORIGIN_X   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ORIGIN_Y   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_SIZE       = 3'd7;

    localparam logic [COST_W-1:0] FULL_COST   = 8'd252;
    localparam logic [COST_W-1:0] LETHAL_COST = 8'd254;
    localparam logic [STR_W-1:0]  WEAK_LIMIT  = 24'd1280;

    // Configuration as the datapath sees it, with the zero cases resolved.
    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [STR_W-1:0]   strength;
        logic [R_W-1:0]     radius2;
        logic [STR_W-1:0]   limit;
        logic [COORD_W-1:0] org_x;
        logic [COORD_W-1:0] org_y;
        logic [CS_W-1:0]    cell_size;
        logic               src_on;
    } cfg_t;

    // A classified cell waiting for the cost datapath.
    typedef struct packed {
        logic [COST_W-1:0] prior;
        logic              active;
        logic [R_W-1:0]    dx;
        logic [R_W-1:0]    dy;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_xfer_t;

endpackage

/* sv/rscc_front.sv */
// Front end: takes a cell, forms the axis offsets to the source and classifies it.
// Depends on rscc_pkg.
module rscc_front
    import rscc_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [IDX_IN_W-1:0] cell_col,
    input  logic [IDX_IN_W-1:0] cell_row,
    input  logic [COST_W-1:0]   prior_cost,
    input  cfg_t                cfg,
    output job_xfer_t           job_out
);

    localparam int IDX_W = (INDEX_BITS < IDX_IN_W) ? INDEX_BITS : IDX_IN_W;
    localparam int PW    = IDX_W + 1 + CS_W;
    localparam int OW    = ((PW > COORD_W + 1) ? PW : COORD_W + 1) + 2;

    logic              v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]  col0_reg, row0_reg;
    logic [COST_W-1:0] prior0_reg, prior1_reg, prior2_reg;
    logic [PW-1:0]     px1_reg, py1_reg;
    logic [OW-1:0]     offx2_reg, offy2_reg;
    job_t              job3_reg;

    logic [OW-1:0]     org2x, org2y, src2x, src2y;
    logic [OW-1:0]     absx, absy, rad_ext;
    logic              inbox;

    always_comb
    begin
        org2x   = {{(OW-COORD_W-1){cfg.org_x[COORD_W-1]}}, cfg.org_x, 1'b0};
        org2y   = {{(OW-COORD_W-1){cfg.org_y[COORD_W-1]}}, cfg.org_y, 1'b0};
        src2x   = {{(OW-COORD_W-1){cfg.src_x[COORD_W-1]}}, cfg.src_x, 1'b0};
        src2y   = {{(OW-COORD_W-1){cfg.src_y[COORD_W-1]}}, cfg.src_y, 1'b0};
        absx    = offx2_reg[OW-1] ? (~offx2_reg + 1'b1) : offx2_reg;
        absy    = offy2_reg[OW-1] ? (~offy2_reg + 1'b1) : offy2_reg;
        rad_ext = {{(OW-R_W){1'b0}}, cfg.radius2};
        inbox   = (absx <= rad_ext) && (absy <= rad_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col0_reg   <= cell_col[IDX_W-1:0];
        row0_reg   <= cell_row[IDX_W-1:0];
        prior0_reg <= prior_cost;
        // Centre of the cell in doubled units is origin*2 + (2*index+1)*cell_size.
        px1_reg    <= {col0_reg, 1'b1} * cfg.cell_size;
        py1_reg    <= {row0_reg, 1'b1} * cfg.cell_size;
        prior1_reg <= prior0_reg;
        offx2_reg  <= org2x + {{(OW-PW){1'b0}}, px1_reg} - src2x;
        offy2_reg  <= org2y + {{(OW-PW){1'b0}}, py1_reg} - src2y;
        prior2_reg <= prior1_reg;
        job3_reg.prior  <= prior2_reg;
        job3_reg.active <= cfg.src_on && inbox;
        job3_reg.dx     <= absx[R_W-1:0];
        job3_reg.dy     <= absy[R_W-1:0];
    end

    assign job_out.valid = v3_reg;
    assign job_out.job   = job3_reg;

endmodule

/* sv/rscc_queue.sv */
// Short queue between the front end and the cost datapath.
// Depends on rscc_pkg.
module rscc_queue
    import rscc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_xfer_t push_in,
    output job_xfer_t pop_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic             out_valid_reg;
    job_t             out_job_reg;

    assign pop = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        case ({push_in.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= pop;
            if (push_in.valid)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // The entry being read was written at an earlier edge, so a push in the same
    // cycle never targets it.
    always_ff @(posedge clk)
    begin
        if (push_in.valid)
            mem[wr_ptr_reg] <= push_in.job;
        if (pop)
            out_job_reg <= mem[rd_ptr_reg];
    end

    assign pop_out.valid = out_valid_reg;
    assign pop_out.job   = out_job_reg;

endmodule

/* sv/rscc_back.sv */
// Cost datapath: squared distance, pipelined square root, scaling and division.
// Depends on rscc_pkg.
module rscc_back
    import rscc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_xfer_t         job_in,
    input  cfg_t              cfg,
    output logic              done,
    output logic [COST_W-1:0] new_cost,
    output logic              in_reach
);

    localparam int SQ_N  = R_W;
    localparam int REM_W = R_W + 2;

    logic [D2_W-1:0]  rr_reg;
    logic [DEN_W-1:0] den_reg;

    logic              v0_reg, v1_reg;
    job_t              job0_reg;
    logic [COST_W-1:0] prior1_reg;
    logic              act1_reg;
    logic [D2_W-1:0]   sqx1_reg, sqy1_reg;
    logic [D2_W:0]     d2;

    logic              sq_v_reg     [0:SQ_N];
    logic [COST_W-1:0] sq_prior_reg [0:SQ_N];
    logic              sq_inr_reg   [0:SQ_N];
    logic [D2_W-1:0]   sq_val_reg   [0:SQ_N];
    logic [REM_W-1:0]  sq_rem_reg   [0:SQ_N];
    logic [R_W-1:0]    sq_root_reg  [0:SQ_N];

    logic              m1_v_reg, m2_v_reg;
    logic [COST_W-1:0] m1_prior_reg, m2_prior_reg;
    logic              m1_inr_reg, m2_inr_reg;
    logic [NUM1_W-1:0] num1_reg;
    logic [NUM_W-1:0]  num_reg;

    logic              dv_v_reg     [0:QUOT_W];
    logic [COST_W-1:0] dv_prior_reg [0:QUOT_W];
    logic              dv_inr_reg   [0:QUOT_W];
    logic              dv_cap_reg   [0:QUOT_W];
    logic [NUM_W-1:0]  dv_rem_reg   [0:QUOT_W];
    logic [QUOT_W-1:0] dv_q_reg     [0:QUOT_W];

    logic              done_reg, reach_reg;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] c_final;

    assign d2 = {1'b0, sqx1_reg} + {1'b0, sqy1_reg};

    // Cfg products; user changes configuration only while block idle; unenforced.
    always_ff @(posedge clk)
    begin
        rr_reg  <= cfg.radius2 * cfg.radius2;
        den_reg <= cfg.limit * cfg.radius2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else
        begin
            v0_reg      <= job_in.valid;
            v1_reg      <= v0_reg;
            sq_v_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        job0_reg        <= job_in.job;
        prior1_reg      <= job0_reg.prior;
        act1_reg        <= job0_reg.active;
        sqx1_reg        <= job0_reg.dx * job0_reg.dx;
        sqy1_reg        <= job0_reg.dy * job0_reg.dy;
        sq_prior_reg[0] <= prior1_reg;
        sq_inr_reg[0]   <= act1_reg && (d2 <= {1'b0, rr_reg});
        sq_val_reg[0]   <= d2[D2_W-1:0];
        sq_rem_reg[0]   <= '0;
        sq_root_reg[0]  <= '0;
    end

    // One result bit of the integer square root per stage.
    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_sh, trial;
        logic             take;

        always_comb
        begin
            rem_sh = {sq_rem_reg[i][REM_W-3:0], sq_val_reg[i][D2_W-1:D2_W-2]};
            trial  = {sq_root_reg[i], 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[i+1] <= 1'b0;
            else
                sq_v_reg[i+1] <= sq_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            sq_prior_reg[i+1] <= sq_prior_reg[i];
            sq_inr_reg[i+1]   <= sq_inr_reg[i];
            sq_val_reg[i+1]   <= {sq_val_reg[i][D2_W-3:0], 2'b00};
            sq_rem_reg[i+1]   <= take ? (rem_sh - trial) : rem_sh;
            sq_root_reg[i+1]  <= {sq_root_reg[i][R_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg    <= 1'b0;
            m2_v_reg    <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            m1_v_reg    <= sq_v_reg[SQ_N];
            m2_v_reg    <= m1_v_reg;
            dv_v_reg[0] <= m2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_prior_reg    <= sq_prior_reg[SQ_N];
        m1_inr_reg      <= sq_inr_reg[SQ_N];
        num1_reg        <= cfg.strength * (cfg.radius2 - sq_root_reg[SQ_N]);
        m2_prior_reg    <= m1_prior_reg;
        m2_inr_reg      <= m1_inr_reg;
        // Times 252 as times 256 minus times 4.
        num_reg         <= {num1_reg, 8'd0} - {6'd0, num1_reg, 2'd0};
        dv_prior_reg[0] <= m2_prior_reg;
        dv_inr_reg[0]   <= m2_inr_reg;
        dv_cap_reg[0]   <= (num_reg >= {den_reg, 8'd0});
        dv_rem_reg[0]   <= num_reg;
        dv_q_reg[0]     <= '0;
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        logic [NUM_W-1:0] sub;
        logic             take;

        always_comb
        begin
            sub  = NUM_W'(den_reg) << (QUOT_W - 1 - j);
            take = (dv_rem_reg[j] >= sub);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            dv_prior_reg[j+1] <= dv_prior_reg[j];
            dv_inr_reg[j+1]   <= dv_inr_reg[j];
            dv_cap_reg[j+1]   <= dv_cap_reg[j];
            dv_rem_reg[j+1]   <= take ? (dv_rem_reg[j] - sub) : dv_rem_reg[j];
            dv_q_reg[j+1]     <= {dv_q_reg[j][QUOT_W-2:0], take};
        end
    end

    always_comb
    begin
        if (dv_cap_reg[QUOT_W] || (dv_q_reg[QUOT_W] > FULL_COST))
            c_final = FULL_COST;
        else
            c_final = dv_q_reg[QUOT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_v_reg[QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        reach_reg <= dv_inr_reg[QUOT_W];
        if (dv_inr_reg[QUOT_W] && (dv_prior_reg[QUOT_W] != LETHAL_COST)
            && (c_final > dv_prior_reg[QUOT_W]))
            cost_reg <= c_final;
        else
            cost_reg <= dv_prior_reg[QUOT_W];
    end

    assign done     = done_reg;
    assign new_cost = cost_reg;
    assign in_reach = done_reg & reach_reg;

endmodule

/* sv/radial_source_cost_cell_top.sv */
// Top level of the radial source cost cell: configuration registers and the
// front end, queue and cost datapath. Depends on rscc_pkg and the three submodules.
//
//   channel   ports                                   transaction marker
//   cell in   cell_col, cell_row, prior_cost          start high, busy low
//   result    new_cost, in_reach                      done high for one cycle
//   config    cfg_we, cfg_addr, cfg_wdata             cfg_we high
//
// One cell is accepted per clock cycle while busy is low. Each result passes, after its
// transaction is accepted, through four front-end stages, two through the queue (write and
// registered read), three squaring stages, the 21-stage square root, three scaling
// stages, the 8-stage division and the output register.
// Reset is asynchronous and active low; it empties the pipeline and the queue and
// loads the configuration reset values.
// The receiver cannot stall. busy rises only when the queue and the front end
// together hold as many cells as the queue has entries; at full rate they hold six.
module radial_source_cost_cell_top
    import rscc_pkg::*;
#(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [IDX_IN_W-1:0]   cell_col,
    input  logic [IDX_IN_W-1:0]   cell_row,
    input  logic [COST_W-1:0]     prior_cost,
    output logic                  done,
    output logic [COST_W-1:0]     new_cost,
    output logic                  in_reach,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int OC_W = $clog2(QUEUE_DEPTH + 1);

    logic [COORD_W-1:0] source_pos_x_reg, source_pos_y_reg;
    logic [STR_W-1:0]   source_strength_reg;
    logic [RAD_W-1:0]   reach_radius_reg;
    logic [STR_W-1:0]   strength_limit_reg;
    logic [COORD_W-1:0] grid_origin_x_reg, grid_origin_y_reg;
    logic [CS_W-1:0]    cell_size_reg;

    cfg_t               cfg;
    job_xfer_t          front_job, queue_job;
    logic               accept;
    logic [OC_W-1:0]    outstanding_reg, outstanding_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_pos_x_reg    <= '0;
            source_pos_y_reg    <= '0;
            source_strength_reg <= '0;
            reach_radius_reg    <= 20'd1024;
            strength_limit_reg  <= 24'd128000;
            grid_origin_x_reg   <= '0;
            grid_origin_y_reg   <= '0;
            cell_size_reg       <= 16'd51;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SOURCE_POS_X:    source_pos_x_reg    <= cfg_wdata;
                REG_SOURCE_POS_Y:    source_pos_y_reg    <= cfg_wdata;
                REG_SOURCE_STRENGTH: source_strength_reg <= cfg_wdata[STR_W-1:0];
                REG_REACH_RADIUS:    reach_radius_reg    <= cfg_wdata[RAD_W-1:0];
                REG_STRENGTH_LIMIT:  strength_limit_reg  <= cfg_wdata[STR_W-1:0];
                REG_GRID_ORIGIN_X:   grid_origin_x_reg   <= cfg_wdata;
                REG_GRID_ORIGIN_Y:   grid_origin_y_reg   <= cfg_wdata;
                REG_CELL_SIZE:       cell_size_reg       <= cfg_wdata[CS_W-1:0];
                default:             ;
            endcase
        end
    end

    // A zero radius or limit acts as one; the radius is kept in doubled units.
    always_comb
    begin
        cfg.src_x     = source_pos_x_reg;
        cfg.src_y     = source_pos_y_reg;
        cfg.strength  = source_strength_reg;
        cfg.radius2   = (reach_radius_reg == '0) ? R_W'(2) : {reach_radius_reg, 1'b0};
        cfg.limit     = (strength_limit_reg == '0) ? STR_W'(1) : strength_limit_reg;
        cfg.org_x     = grid_origin_x_reg;
        cfg.org_y     = grid_origin_y_reg;
        cfg.cell_size = cell_size_reg;
        cfg.src_on    = (source_strength_reg > WEAK_LIMIT);
    end

    // Cells accepted but not yet taken from the queue; this keeps the queue
    // from ever overflowing since the datapath drains it every cycle.
    assign busy   = (outstanding_reg == OC_W'(QUEUE_DEPTH));
    assign accept = start & ~busy;

    always_comb
    begin
        case ({accept, queue_job.valid})
            2'b10:   outstanding_next = outstanding_reg + 1'b1;
            2'b01:   outstanding_next = outstanding_reg - 1'b1;
            default: outstanding_next = outstanding_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    rscc_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .prior_cost (prior_cost),
        .cfg        (cfg),
        .job_out    (front_job)
    );

    rscc_queue #(
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (front_job),
        .pop_out (queue_job)
    );

    rscc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_in   (queue_job),
        .cfg      (cfg),
        .done     (done),
        .new_cost (new_cost),
        .in_reach (in_reach)
    );

endmodule

/* sv/rscc_checker.sv */
// Port-level checker for the radial source cost cell, bound to the top level.
// Depends on radial_source_cost_cell_top_defines.svh.
`include "radial_source_cost_cell_top_defines.svh"

module rscc_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic in_reach
);

    `RSCC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> (!busy && !done), "active during reset")
    `RSCC_ASSERT(a_reach_with_done, clk, rst_n, in_reach |-> done, "in_reach without a result")
    `RSCC_ASSERT(a_busy_after_accept, clk, rst_n, $rose(busy) |-> $past(start && !busy), "busy rose without a transaction")

endmodule

bind radial_source_cost_cell_top rscc_checker u_rscc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .in_reach (in_reach)
);
